@@ rtl/core/device_number_reservation_table_top_macros.svh @@
// Assertion macros for the device number reservation table.
`ifndef DEVICE_NUMBER_RESERVATION_TABLE_TOP_MACROS_SVH
`define DEVICE_NUMBER_RESERVATION_TABLE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold at every clock edge out of reset.
`define DNRT_ASSERT(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("dnrt: invariant violated");

// When pre holds, post must hold in the next cycle.
`define DNRT_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("dnrt: sequence violated");

`else

`define DNRT_ASSERT(label, cond)
`define DNRT_ASSERT_NEXT(label, pre, post)

`endif

`endif

@@ rtl/core/dnrt_pkg.sv @@
// Shared types, constants and helpers of the device number reservation table.
package dnrt_pkg;

	// Parameter defaults and limits
	localparam int TABLE_ENTRIES_DEF = 8;
	localparam int TABLE_ENTRIES_MAX = 64;
	localparam int ID_BYTES_DEF      = 16;
	localparam int PICK_W            = $clog2(TABLE_ENTRIES_MAX);

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_START     = 2'd1;

	// Register reset values
	localparam logic [31:0] RESERVED_START_RST = 32'd10000;
	localparam logic [31:0] AUTO_START_RST     = 32'd20000;

	// Search token handed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              hit;
		logic [31:0]       hit_nr;
		logic [31:0]       key;
		logic [PICK_W-1:0] pick;
	} tok_t;

	// Entry write broadcast to all cells
	typedef struct packed {
		logic              en;
		logic [PICK_W-1:0] pick;
		logic [63:0]       id_lo;
		logic [63:0]       id_hi;
		logic [31:0]       nr;
	} wr_t;

	// Mask of the ID bytes kept in the low word
	function automatic logic [63:0] id_mask_lo(int bytes);
		logic [63:0] m;
		if (bytes >= 8) begin
			m = '1;
		end else if (bytes <= 0) begin
			m = '0;
		end else begin
			m = (64'd1 << (8 * bytes)) - 64'd1;
		end
		return m;
	endfunction

	// Mask of the ID bytes kept in the high word
	function automatic logic [63:0] id_mask_hi(int bytes);
		return id_mask_lo(bytes - 8);
	endfunction

endpackage

@@ rtl/core/dnrt_cell.sv @@
// One table entry: ID match, oldest-number selection and entry storage.
module dnrt_cell
	import dnrt_pkg::*;
#(
	parameter int INDEX = 0
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [63:0] id_lo,
	input  logic [63:0] id_hi,
	input  logic [31:0] rn,
	input  logic [31:0] auto_start,
	input  tok_t        tok_in,
	input  wr_t         wr,
	output tok_t        tok_out,
	output logic [31:0] nr
);

	logic [63:0] ent_lo_q;
	logic [63:0] ent_hi_q;
	logic [31:0] ent_nr_q;
	tok_t        tok_q;
	tok_t        tok_nxt;
	logic [31:0] key_a;
	logic [PICK_W-1:0] pick_a;
	logic [31:0] wrapped;

	// Match and selection on the passing token
	always_comb begin
		tok_nxt = tok_in;
		if (!tok_in.hit && ent_lo_q == id_lo && ent_hi_q == id_hi) begin
			tok_nxt.hit    = 1'b1;
			tok_nxt.hit_nr = ent_nr_q;
		end
		key_a  = tok_in.key;
		pick_a = tok_in.pick;
		if (ent_nr_q >= rn && ent_nr_q < key_a) begin
			key_a  = ent_nr_q;
			pick_a = PICK_W'(INDEX);
		end
		wrapped = ent_nr_q + auto_start;
		if (wrapped < key_a) begin
			key_a  = wrapped;
			pick_a = PICK_W'(INDEX);
		end
		tok_nxt.key  = key_a;
		tok_nxt.pick = pick_a;
	end

	// Token register toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	// Entry storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_lo_q <= '0;
			ent_hi_q <= '0;
			ent_nr_q <= '0;
		end else if (wr.en && wr.pick == PICK_W'(INDEX)) begin
			ent_lo_q <= wr.id_lo;
			ent_hi_q <= wr.id_hi;
			ent_nr_q <= wr.nr;
		end
	end

	assign tok_out = tok_q;
	assign nr      = ent_nr_q;

endmodule

@@ rtl/core/device_number_reservation_table_top.sv @@
// Top level of the device number reservation table.
//
//   channel  | signals                                   | flow
//   request  | req_valid, req_stall, id_low, id_high     | in, stall driven here
//   response | rsp_valid, rsp_stall, assigned_nr, flags  | out, stall driven by sink
//   config   | cfg_valid, cfg_ready, cfg_index, cfg_data | in, ready always high
//
// An all-zero ID goes straight to the result state; a nonzero ID first sends a
// token along the chain of entry cells, one cell per cycle. One word is in
// flight at a time; req_stall is high until the result is handed to the
// response register. The response register holds a word under rsp_stall
// while the next request is taken. Reset clears the table to zero and loads
// the register defaults; no clearing pass is needed.
`include "device_number_reservation_table_top_macros.svh"

module device_number_reservation_table_top
	import dnrt_pkg::*;
#(
	parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
	parameter int ID_BYTES      = ID_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [63:0]          id_low,
	input  logic [63:0]          id_high,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output logic [31:0]          assigned_nr,
	output logic                 from_table,
	output logic                 was_known,
	output logic                 out_of_numbers,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_RESULT = 3'b100
	} state_t;

	localparam logic [63:0] MASK_LO = id_mask_lo(ID_BYTES);
	localparam logic [63:0] MASK_HI = id_mask_hi(ID_BYTES);

	state_t      state_q;
	logic [31:0] reserved_start_q;
	logic [31:0] auto_start_q;
	logic [31:0] plain_counter_q;
	logic [31:0] reserve_next_q;
	logic [63:0] id_lo_q;
	logic [63:0] id_hi_q;
	logic [31:0] rn_q;
	tok_t        head_q;
	logic [31:0] res_nr_q;
	logic        res_table_q;
	logic        res_known_q;
	logic        res_oon_q;
	logic        rsp_valid_q;
	logic [31:0] assigned_nr_q;
	logic        from_table_q;
	logic        was_known_q;
	logic        oon_q;

	logic        req_take;
	logic        rsp_free;
	logic [63:0] id_lo_m;
	logic [63:0] id_hi_m;
	logic        id_zero;
	logic [31:0] win_top;
	logic [31:0] rn_clamp;
	logic [31:0] key_init;
	tok_t        chain [TABLE_ENTRIES+1];
	logic [31:0] cell_nr [TABLE_ENTRIES];
	logic [TABLE_ENTRIES:0] chain_valid;
	tok_t        last;
	wr_t         wr;

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign cfg_ready = 1'b1;

	// ID masking and window clamp
	assign id_lo_m  = id_low & MASK_LO;
	assign id_hi_m  = id_high & MASK_HI;
	assign id_zero  = (id_lo_m == '0) && (id_hi_m == '0);
	assign win_top  = auto_start_q - 32'd2;
	assign rn_clamp = (reserve_next_q < reserved_start_q || reserve_next_q > win_top) ?
		reserved_start_q : reserve_next_q;
	assign key_init = (cell_nr[0] < rn_clamp) ? cell_nr[0] + auto_start_q : cell_nr[0];

	// Cell chain
	assign chain[0] = head_q;
	assign last     = chain[TABLE_ENTRIES];

	generate
		for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
			dnrt_cell #(
				.INDEX (i)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.id_lo      (id_lo_q),
				.id_hi      (id_hi_q),
				.rn         (rn_q),
				.auto_start (auto_start_q),
				.tok_in     (chain[i]),
				.wr         (wr),
				.tok_out    (chain[i+1]),
				.nr         (cell_nr[i])
			);
		end
		for (genvar j = 0; j <= TABLE_ENTRIES; j++) begin : g_valid
			assign chain_valid[j] = chain[j].valid;
		end
	endgenerate

	// Entry replacement on a miss
	always_comb begin
		wr.en    = last.valid && !last.hit;
		wr.pick  = last.pick;
		wr.id_lo = id_lo_q;
		wr.id_hi = id_hi_q;
		wr.nr    = rn_q;
	end

	// Control, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			reserved_start_q <= RESERVED_START_RST;
			auto_start_q     <= AUTO_START_RST;
			plain_counter_q  <= AUTO_START_RST;
			reserve_next_q   <= '0;
			head_q           <= '0;
			rsp_valid_q      <= 1'b0;
		end else begin
			// token launch for a nonzero ID
			head_q.valid <= (state_q == ST_IDLE) && req_take && !id_zero;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_RESERVED_START: reserved_start_q <= cfg_data;
					CFG_AUTO_START: begin
						auto_start_q    <= cfg_data;
						plain_counter_q <= cfg_data;
					end
					default: ;
				endcase
			end
			// response valid: set on handoff, cleared when taken
			if (state_q == ST_RESULT && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						if (id_zero) begin
							if (plain_counter_q != '0) begin
								plain_counter_q <= plain_counter_q + 32'd1;
							end
							state_q <= ST_RESULT;
						end else begin
							head_q.hit    <= 1'b0;
							head_q.hit_nr <= '0;
							head_q.key    <= key_init;
							head_q.pick   <= '0;
							state_q       <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (last.valid) begin
						if (!last.hit) begin
							reserve_next_q <= rn_q + 32'd1;
						end
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (req_take) begin
			id_lo_q <= id_lo_m;
			id_hi_q <= id_hi_m;
			rn_q    <= rn_clamp;
			if (id_zero) begin
				res_table_q <= 1'b0;
				res_known_q <= 1'b0;
				if (plain_counter_q != '0) begin
					res_nr_q  <= plain_counter_q;
					res_oon_q <= 1'b0;
				end else begin
					res_nr_q  <= 32'd1;
					res_oon_q <= 1'b1;
				end
			end
		end
		if (state_q == ST_SCAN && last.valid) begin
			res_table_q <= 1'b1;
			res_oon_q   <= 1'b0;
			res_known_q <= last.hit;
			res_nr_q    <= last.hit ? last.hit_nr : rn_q;
		end
		if (state_q == ST_RESULT && rsp_free) begin
			assigned_nr_q <= res_nr_q;
			from_table_q  <= res_table_q;
			was_known_q   <= res_known_q;
			oon_q         <= res_oon_q;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign assigned_nr    = assigned_nr_q;
	assign from_table     = from_table_q;
	assign was_known      = was_known_q;
	assign out_of_numbers = oon_q;

	// Checks
	`DNRT_ASSERT(a_state_onehot, $onehot(state_q))
	`DNRT_ASSERT(a_one_token, $onehot0(chain_valid))
	`DNRT_ASSERT(a_token_in_scan, !last.valid || state_q == ST_SCAN)
	`DNRT_ASSERT_NEXT(a_result_out, state_q == ST_RESULT && rsp_free, rsp_valid && state_q == ST_IDLE)

endmodule

@@ verif/tb_device_number_reservation_table_top.sv @@
// Self-checking testbench for the device number reservation table top level.
module tb_device_number_reservation_table_top
	import dnrt_pkg::*;
();

	localparam int CLK_PERIOD  = 8;
	localparam int NUM_ENTRIES = 8;
	localparam int ID_LEN      = 16;
	localparam int POOL_SIZE   = 12;
	localparam int PHASES      = 11;
	localparam int PHASE_ITEMS = 150;
	localparam int QUIET_PHASE = 5;
	localparam logic [127:0] ID_KEEP = (ID_LEN >= 16) ? {128{1'b1}} :
		((128'd1 << (8 * ID_LEN)) - 128'd1);
	localparam logic [31:0] NR_MAX = 32'hFFFF_FFFF;

	// Register indexes the block does not decode
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_3 = 2'd3;

	typedef struct packed {
		logic [31:0] nr;
		logic        table_path;
		logic        known;
		logic        exhausted;
	} dev_word_t;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	// One directed step: a request, or a register write with its value in lo
	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [63:0]          lo;
		logic [63:0]          hi;
		logic                 typed;
		logic [31:0]          nr;
		logic                 tbl;
		logic                 known;
		logic                 oon;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	logic [63:0]          id_low;
	logic [63:0]          id_high;
	logic                 rsp_valid;
	logic                 rsp_stall;
	logic [31:0]          assigned_nr;
	logic                 from_table;
	logic                 was_known;
	logic                 out_of_numbers;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;

	// Predictor state
	logic [31:0]  resv_start;
	logic [31:0]  auto_base;
	logic [31:0]  plain_count;
	logic [31:0]  next_reserve;
	logic [127:0] tbl_id [NUM_ENTRIES];
	logic [31:0]  tbl_nr [NUM_ENTRIES];

	dev_word_t    pending_numbers[$];
	plan_row_t    plan[$];
	logic [127:0] id_pool [POOL_SIZE];
	int           mismatches;
	logic         quiet;

	device_number_reservation_table_top #(
		.TABLE_ENTRIES(NUM_ENTRIES),
		.ID_BYTES(ID_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.id_low(id_low),
		.id_high(id_high),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.assigned_nr(assigned_nr),
		.from_table(from_table),
		.was_known(was_known),
		.out_of_numbers(out_of_numbers),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// Number assignment for one request; updates the predictor state
	function automatic dev_word_t assign_number(logic [63:0] lo, logic [63:0] hi);
		logic [127:0] id;
		logic [31:0]  top;
		logic [31:0]  key;
		logic [31:0]  held;
		logic [31:0]  wrapped;
		int           pick;
		dev_word_t    res;
		id = {hi, lo} & ID_KEEP;
		res = '0;
		// all-zero ID: plain counter path
		if (id == '0) begin
			if (plain_count != '0) begin
				res.nr = plain_count;
				plain_count = plain_count + 32'd1;
			end else begin
				res.nr = 32'd1;
				res.exhausted = 1'b1;
			end
			return res;
		end
		res.table_path = 1'b1;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			if (tbl_id[i] == id) begin
				res.nr = tbl_nr[i];
				res.known = 1'b1;
				return res;
			end
		end
		// miss: clamp pointer into window, evict the oldest number
		top = auto_base - 32'd2;
		if (next_reserve < resv_start || next_reserve > top) begin
			next_reserve = resv_start;
		end
		key = tbl_nr[0];
		if (key < next_reserve) begin
			key = key + auto_base;
		end
		pick = 0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			held = tbl_nr[i];
			wrapped = held + auto_base;
			if (held >= next_reserve && held < key) begin
				pick = i;
				key = held;
			end
			if (wrapped < key) begin
				pick = i;
				key = wrapped;
			end
		end
		tbl_nr[pick] = next_reserve;
		tbl_id[pick] = id;
		res.nr = next_reserve;
		next_reserve = next_reserve + 32'd1;
		return res;
	endfunction

	function automatic logic [127:0] random_id();
		logic [127:0] v;
		case ($urandom_range(5))
			0: v = {{$urandom, $urandom}, 64'd0};
			1: v = {64'd0, {$urandom, $urandom}};
			2: v = 128'd1 << $urandom_range(127);
			3: v = ~(128'd1 << $urandom_range(127));
			default: v = {$urandom, $urandom, $urandom, $urandom};
		endcase
		return v;
	endfunction

	// Present one request word, with random idle cycles ahead of it
	task automatic send_request(logic [63:0] lo, logic [63:0] hi, logic typed,
			dev_word_t want);
		dev_word_t got;
		@(negedge clk);
		while (!quiet && $urandom_range(99) < 24) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		id_low    <= lo;
		id_high   <= hi;
		do @(posedge clk); while (req_stall);
		got = assign_number(lo, hi);
		pending_numbers.push_back(typed ? want : got);
	endtask

	// Drop the request and wait until every expected word has come back
	task automatic settle_block();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_numbers.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_RESERVED_START) begin
			resv_start = val;
		end else if (idx == CFG_AUTO_START) begin
			auto_base = val;
			plain_count = val;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Response side stall
	always @(negedge clk) begin
		rsp_stall <= !quiet && ($urandom_range(99) < 24);
	end

	// Compare each response word with the oldest expectation
	always @(posedge clk) begin : check_words
		dev_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_numbers.size() == 0) begin
				$display("%0t unexpected word: expected none, got nr %0d", $time,
					assigned_nr);
				mismatches++;
			end else begin
				want = pending_numbers.pop_front();
				if (assigned_nr !== want.nr) begin
					$display("%0t assigned_nr: expected %0d, got %0d", $time, want.nr,
						assigned_nr);
					mismatches++;
				end
				if (from_table !== want.table_path) begin
					$display("%0t from_table: expected %0b, got %0b", $time,
						want.table_path, from_table);
					mismatches++;
				end
				if (was_known !== want.known) begin
					$display("%0t was_known: expected %0b, got %0b", $time, want.known,
						was_known);
					mismatches++;
				end
				if (out_of_numbers !== want.exhausted) begin
					$display("%0t out_of_numbers: expected %0b, got %0b", $time,
						want.exhausted, out_of_numbers);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#(CLK_PERIOD * 2_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		dev_word_t    want;
		logic [127:0] id;
		logic [31:0]  rs_val;
		logic [31:0]  as_val;
		int           roll;
		clk         = 1'b0;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		id_low      = '0;
		id_high     = '0;
		rsp_stall   = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_RESERVED_START;
		cfg_data    = '0;
		quiet       = 1'b0;
		mismatches  = 0;
		resv_start  = RESERVED_START_RST;
		auto_base   = AUTO_START_RST;
		plain_count = AUTO_START_RST;
		next_reserve = '0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			tbl_id[i] = '0;
			tbl_nr[i] = '0;
		end

		// Directed steps; typed rows carry their own expectation
		plan.push_back('{ROW_REQ, '0, 64'd0, 64'd0, 1'b1, 32'd20000, 1'b0, 1'b0, 1'b0});
		plan.push_back('{ROW_REQ, '0, 64'd0, 64'd0, 1'b1, 32'd20001, 1'b0, 1'b0, 1'b0});
		plan.push_back('{ROW_REQ, '0, 64'd1, 64'd0, 1'b1, 32'd10000, 1'b1, 1'b0, 1'b0});
		plan.push_back('{ROW_REQ, '0, 64'd1, 64'd0, 1'b1, 32'd10000, 1'b1, 1'b1, 1'b0});
		plan.push_back('{ROW_REQ, '0, 64'd0, 64'd1, 1'b1, 32'd10001, 1'b1, 1'b0, 1'b0});
		plan.push_back('{ROW_REQ, '0, '1, '1, 1'b1, 32'd10002, 1'b1, 1'b0, 1'b0});
		plan.push_back('{ROW_REQ, '0, '1, '1, 1'b1, 32'd10002, 1'b1, 1'b1, 1'b0});
		plan.push_back('{ROW_REQ, '0, 64'd0, '1, 1'b1, 32'd10003, 1'b1, 1'b0, 1'b0});
		// fill the table and push the first entry out
		plan.push_back('{ROW_REQ, '0, 64'h8000_0000_0000_0000, 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'd0, 64'h8000_0000_0000_0000, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
			1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'd2, 64'd7, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'd1, 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'd0, 64'd0, 1'b1, 32'd20002, 1'b0, 1'b0, 1'b0});
		// counter at its top, then out of numbers
		plan.push_back('{ROW_CFG, CFG_AUTO_START, 64'(NR_MAX), 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'd0, 64'd0, 1'b1, NR_MAX, 1'b0, 1'b0, 1'b0});
		plan.push_back('{ROW_REQ, '0, 64'd0, 64'd0, 1'b1, 32'd1, 1'b0, 1'b0, 1'b1});
		plan.push_back('{ROW_REQ, '0, 64'd0, 64'd0, 1'b1, 32'd1, 1'b0, 1'b0, 1'b1});
		// window bound wraps, pointer runs past the top
		plan.push_back('{ROW_CFG, CFG_RESERVED_START, 64'hFFFF_FFFE, 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_CFG, CFG_AUTO_START, 64'd1, 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'd3, 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'd4, 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'd5, 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'd0, 64'd0, 1'b1, 32'd1, 1'b0, 1'b0, 1'b0});
		// undecoded indexes leave the counter alone
		plan.push_back('{ROW_CFG, CFG_UNUSED_2, 64'd0, 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_CFG, CFG_UNUSED_3, 64'(NR_MAX), 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'd0, 64'd0, 1'b1, 32'd2, 1'b0, 1'b0, 1'b0});
		// narrowest window
		plan.push_back('{ROW_CFG, CFG_RESERVED_START, 64'd1, 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_CFG, CFG_AUTO_START, 64'd3, 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'd6, 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'd7, 64'd0, 1'b0, '0, 0, 0, 0});
		plan.push_back('{ROW_REQ, '0, 64'd0, 64'd0, 1'b1, 32'd3, 1'b0, 1'b0, 1'b0});

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			if (plan[r].kind == ROW_CFG) begin
				settle_block();
				write_register(plan[r].reg_idx, plan[r].lo[31:0]);
			end else begin
				want = '{plan[r].nr, plan[r].tbl, plan[r].known, plan[r].oon};
				send_request(plan[r].lo, plan[r].hi, plan[r].typed, want);
			end
		end

		// Random phases, each with its own window and ID pool
		for (int phase = 0; phase < PHASES; phase++) begin
			settle_block();
			quiet = (phase == QUIET_PHASE);
			case ($urandom_range(5))
				0: begin
					rs_val = 32'd1;
					as_val = 32'd3;
				end
				1: begin
					rs_val = 32'hFFFF_FFFD;
					as_val = NR_MAX;
				end
				2: begin
					rs_val = $urandom;
					as_val = $urandom;
				end
				3: begin
					// counter close to wrapping, short window just below it
					as_val = NR_MAX - $urandom_range(100);
					rs_val = as_val - 32'd2 - $urandom_range(12, 1);
				end
				default: begin
					rs_val = $urandom_range(32'hF000_0000, 1);
					as_val = rs_val + 32'd2 + $urandom_range(24, 1);
				end
			endcase
			if ($urandom_range(1) == 1) begin
				write_register(CFG_RESERVED_START, rs_val);
				write_register(CFG_AUTO_START, as_val);
			end else begin
				write_register(CFG_AUTO_START, as_val);
				write_register(CFG_RESERVED_START, rs_val);
			end
			if ($urandom_range(3) == 0) begin
				write_register($urandom_range(1) ? CFG_UNUSED_2 : CFG_UNUSED_3, $urandom);
			end
			for (int p = 0; p < POOL_SIZE; p++) begin
				id_pool[p] = random_id();
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(99);
				if (roll < 18) begin
					id = '0;
				end else if (roll < 70) begin
					id = id_pool[$urandom_range(POOL_SIZE - 1)];
				end else begin
					id = random_id();
					id_pool[$urandom_range(POOL_SIZE - 1)] = id;
				end
				send_request(id[63:0], id[127:64], 1'b0, '0);
			end
		end

		quiet = 1'b0;
		settle_block();
		repeat (NUM_ENTRIES + 8) @(posedge clk);
		if (mismatches == 0 && pending_numbers.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
